@@ hdl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/rc6_pkg.sv @@
`default_nettype none

package rc6_pkg;

    // Default sizes
    localparam int ROUNDS_DEF        = 20;
    localparam int MAX_KEY_BYTES_DEF = 32;

    // Fixed widths
    localparam int WORD_W        = 32;
    localparam int ROT_W         = 5;
    localparam int KEY_REG_W     = 64;
    localparam int KEY_REG_COUNT = 4;
    localparam int KEY_LEN_W     = 6;
    localparam int CFG_IDX_W     = 3;

    // Magic constants and fixed rotations
    localparam logic [WORD_W-1:0]    MAGIC_P  = 32'hB7E15163;
    localparam logic [WORD_W-1:0]    MAGIC_Q  = 32'h9E3779B9;
    localparam logic [ROT_W-1:0]     MULT_ROT = 5'd5;
    localparam logic [ROT_W-1:0]     MIX_ROT  = 5'd3;
    localparam logic [KEY_LEN_W-1:0] KEY_LEN_RST = 6'd16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEY0    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY1    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY2    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY3    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEN = 3'd4;

    typedef struct packed {
        logic              cmd;
        logic [WORD_W-1:0] word_a;
        logic [WORD_W-1:0] word_b;
        logic [WORD_W-1:0] word_c;
        logic [WORD_W-1:0] word_d;
    } t_req;

    typedef struct packed {
        logic [WORD_W-1:0] out_a;
        logic [WORD_W-1:0] out_b;
        logic [WORD_W-1:0] out_c;
        logic [WORD_W-1:0] out_d;
    } t_resp;

    typedef enum logic [1:0] {
        STEP_PRE,
        STEP_ROUND,
        STEP_POST
    } t_step_kind;

    typedef struct packed {
        logic       en;
        logic       enc;
        t_step_kind kind;
    } t_step_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_ks_stat;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KEY,
        ST_FETCH,
        ST_RUN,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        KS_IDLE,
        KS_INIT,
        KS_MIX_A,
        KS_MIX_B
    } t_ks_state;

    function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] x,
                                                 input logic [ROT_W-1:0] n);
        logic [2*WORD_W-1:0] w;
        w = {x, x} << n;
        return w[2*WORD_W-1:WORD_W];
    endfunction

    function automatic logic [WORD_W-1:0] rotr32(input logic [WORD_W-1:0] x,
                                                 input logic [ROT_W-1:0] n);
        logic [2*WORD_W-1:0] w;
        w = {x, x} >> n;
        return w[WORD_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ hdl/rc6_rk_ram.sv @@
`default_nettype none

module rc6_rk_ram
    import rc6_pkg::*;
#(
    parameter int ROUNDS = ROUNDS_DEF
)(
    input  logic                              i_clk,
    input  logic                              i_wr_en,
    input  logic [$clog2(2*ROUNDS+4)-1:0]     i_wr_addr,
    input  logic [WORD_W-1:0]                 i_wr_data,
    input  logic [$clog2(2*ROUNDS+4)-1:0]     i_rd0_addr,
    output logic [WORD_W-1:0]                 o_rd0_data,
    input  logic [$clog2(2*ROUNDS+4)-1:0]     i_rd1_addr,
    output logic [WORD_W-1:0]                 o_rd1_data
);

    localparam int DEPTH = 2*ROUNDS + 4;

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rd0_data;
    logic [WORD_W-1:0] r_rd1_data;

    // Write one round key, read two through registered read ports
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd0_data <= r_mem[i_rd0_addr];
        r_rd1_data <= r_mem[i_rd1_addr];
    end

    assign o_rd0_data = r_rd0_data;
    assign o_rd1_data = r_rd1_data;

endmodule

`default_nettype wire

@@ hdl/rc6_key_sched.sv @@
`default_nettype none

module rc6_key_sched
    import rc6_pkg::*;
#(
    parameter int ROUNDS        = ROUNDS_DEF,
    parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
)(
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic [KEY_REG_COUNT*KEY_REG_W-1:0]     i_key,
    input  logic [KEY_LEN_W-1:0]                   i_key_len,
    output t_ks_stat                               o_stat,
    output logic                                   o_rk_wr_en,
    output logic [$clog2(2*ROUNDS+4)-1:0]          o_rk_wr_addr,
    output logic [WORD_W-1:0]                      o_rk_wr_data,
    output logic [$clog2(2*ROUNDS+4)-1:0]          o_rk_rd_addr,
    input  logic [WORD_W-1:0]                      i_rk_rd_data
);

    localparam int RK_COUNT = 2*ROUNDS + 4;
    localparam int RKW      = $clog2(RK_COUNT);
    localparam int KW_COUNT = (MAX_KEY_BYTES + 3) / 4;
    localparam int KWW      = (KW_COUNT > 1) ? $clog2(KW_COUNT) : 1;
    localparam int NWW      = $clog2(KW_COUNT + 1);
    localparam int INIT_LEN = (RK_COUNT > KW_COUNT) ? RK_COUNT : KW_COUNT;
    localparam int CW       = $clog2(INIT_LEN);
    localparam int SCW      = $clog2(3*INIT_LEN + 1);

    t_ks_state         r_state;
    t_ks_state         n_state;
    logic [CW-1:0]     r_cnt;
    logic [SCW-1:0]    r_left;
    logic [WORD_W-1:0] r_s;
    logic [WORD_W-1:0] r_a;
    logic [WORD_W-1:0] r_b;
    logic [RKW-1:0]    r_ai;
    logic [KWW-1:0]    r_bi;
    logic [NWW-1:0]    r_nw;

    // Key word memory
    logic [WORD_W-1:0] r_kw [KW_COUNT];
    logic [WORD_W-1:0] r_kw_rd;
    logic              kw_we;
    logic [KWW-1:0]    kw_wa;
    logic [WORD_W-1:0] kw_wd;
    logic [KWW-1:0]    kw_ra;

    logic [KEY_LEN_W-1:0] len_sat;
    logic [KEY_LEN_W-1:0] nw_raw;
    logic [NWW-1:0]       nw_calc;
    logic [CW:0]          mix_len;
    logic [SCW-1:0]       steps_calc;
    logic [KWW-1:0]       kw_idx;
    logic [WORD_W-1:0]    key_word;
    logic [KEY_LEN_W-1:0] byte_idx;
    logic [WORD_W-1:0]    a_new;
    logic [WORD_W-1:0]    ab_sum;
    logic [WORD_W-1:0]    b_new;
    logic [RKW-1:0]       ai_next;
    logic [KWW-1:0]       bi_next;
    logic                 last_step;

    // Size the schedule from the key length
    always_comb begin
        len_sat = (i_key_len > KEY_LEN_W'(MAX_KEY_BYTES)) ? KEY_LEN_W'(MAX_KEY_BYTES)
                                                          : i_key_len;
        nw_raw  = (len_sat + KEY_LEN_W'(3)) >> 2;
        nw_calc = (nw_raw == '0) ? NWW'(1) : NWW'(nw_raw);
        mix_len = ((CW+1)'(nw_calc) > (CW+1)'(RK_COUNT)) ? (CW+1)'(nw_calc)
                                                          : (CW+1)'(RK_COUNT);
        steps_calc = (SCW'(mix_len) << 1) + SCW'(mix_len);
    end

    // Pack key bytes into a word, dropping bytes past the key length
    always_comb begin
        kw_idx   = r_cnt[KWW-1:0];
        key_word = i_key[WORD_W*kw_idx +: WORD_W];
        byte_idx = '0;
        for (int m = 0; m < 4; m++) begin
            byte_idx = {1'b0, 3'(kw_idx), 2'(m)};
            if (byte_idx >= len_sat) begin
                key_word[8*m +: 8] = 8'h00;
            end
        end
    end

    // Mixing arithmetic, split over two phases per step
    always_comb begin
        a_new     = rotl32(i_rk_rd_data + r_a + r_b, MIX_ROT);
        ab_sum    = r_a + r_b;
        b_new     = rotl32(r_kw_rd + ab_sum, ab_sum[ROT_W-1:0]);
        ai_next   = (r_ai == RKW'(RK_COUNT - 1)) ? '0 : r_ai + RKW'(1);
        bi_next   = ((NWW'(r_bi) + NWW'(1)) == r_nw) ? '0 : r_bi + KWW'(1);
        last_step = (r_left == SCW'(1));
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            KS_IDLE: begin
                if (i_start) begin
                    n_state = KS_INIT;
                end
            end
            KS_INIT: begin
                if (r_cnt == CW'(INIT_LEN - 1)) begin
                    n_state = KS_MIX_A;
                end
            end
            KS_MIX_A: begin
                n_state = KS_MIX_B;
            end
            KS_MIX_B: begin
                n_state = last_step ? KS_IDLE : KS_MIX_A;
            end
            default: begin
                n_state = KS_IDLE;
            end
        endcase
    end

    // Memory ports and status. The two phases alternate, so an entry written
    // in one phase is read back at the earliest in the next one.
    always_comb begin
        o_rk_wr_en   = 1'b0;
        o_rk_wr_addr = r_ai;
        o_rk_wr_data = a_new;
        o_rk_rd_addr = ai_next;
        kw_we        = 1'b0;
        kw_wa        = r_bi;
        kw_wd        = b_new;
        kw_ra        = r_bi;
        o_stat.busy  = (r_state != KS_IDLE);
        o_stat.done  = 1'b0;
        case (r_state)
            KS_IDLE: begin
            end
            KS_INIT: begin
                o_rk_wr_en   = ({1'b0, r_cnt} < (CW+1)'(RK_COUNT));
                o_rk_wr_addr = r_cnt[RKW-1:0];
                o_rk_wr_data = r_s;
                o_rk_rd_addr = '0;
                kw_we        = ({1'b0, r_cnt} < (CW+1)'(KW_COUNT));
                kw_wa        = kw_idx;
                kw_wd        = key_word;
            end
            KS_MIX_A: begin
                o_rk_wr_en = 1'b1;
            end
            KS_MIX_B: begin
                kw_we       = 1'b1;
                o_stat.done = last_step;
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= KS_IDLE;
            r_cnt   <= '0;
            r_left  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == KS_IDLE) begin
                r_cnt  <= '0;
                r_left <= steps_calc;
            end else if (r_state == KS_INIT) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (r_state == KS_MIX_B) begin
                r_left <= r_left - SCW'(1);
            end
        end
    end

    // Working values
    always_ff @(posedge i_clk) begin
        case (r_state)
            KS_IDLE: begin
                r_s  <= MAGIC_P;
                r_a  <= '0;
                r_b  <= '0;
                r_ai <= '0;
                r_bi <= '0;
                r_nw <= nw_calc;
            end
            KS_INIT: begin
                r_s <= r_s + MAGIC_Q;
            end
            KS_MIX_A: begin
                r_a <= a_new;
            end
            KS_MIX_B: begin
                r_b  <= b_new;
                r_ai <= ai_next;
                r_bi <= bi_next;
            end
            default: begin
            end
        endcase
    end

    // Key word memory, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (kw_we) begin
            r_kw[kw_wa] <= kw_wd;
        end
        r_kw_rd <= r_kw[kw_ra];
    end

endmodule

`default_nettype wire

@@ hdl/rc6_round_unit.sv @@
`default_nettype none

module rc6_round_unit
    import rc6_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_load,
    input  t_req              i_req,
    input  t_step_ctl         i_ctl,
    input  logic [WORD_W-1:0] i_k0,
    input  logic [WORD_W-1:0] i_k1,
    output t_resp             o_resp
);

    logic [WORD_W-1:0] r_a;
    logic [WORD_W-1:0] r_b;
    logic [WORD_W-1:0] r_c;
    logic [WORD_W-1:0] r_d;
    logic [WORD_W-1:0] n_a;
    logic [WORD_W-1:0] n_b;
    logic [WORD_W-1:0] n_c;
    logic [WORD_W-1:0] n_d;
    logic [WORD_W-1:0] x0;
    logic [WORD_W-1:0] x1;
    logic [WORD_W-1:0] t;
    logic [WORD_W-1:0] u;

    // Quadratic mixing on the two words that feed the rotations
    always_comb begin
        x0 = i_ctl.enc ? r_b : r_a;
        x1 = i_ctl.enc ? r_d : r_c;
        t  = rotl32(x0 * {x0[WORD_W-2:0], 1'b1}, MULT_ROT);
        u  = rotl32(x1 * {x1[WORD_W-2:0], 1'b1}, MULT_ROT);
    end

    // One whitening step or one round, words rotated in place
    always_comb begin
        n_a = r_a;
        n_b = r_b;
        n_c = r_c;
        n_d = r_d;
        case (i_ctl.kind)
            STEP_PRE: begin
                if (i_ctl.enc) begin
                    n_b = r_b + i_k0;
                    n_d = r_d + i_k1;
                end else begin
                    n_a = r_a - i_k0;
                    n_c = r_c - i_k1;
                end
            end
            STEP_ROUND: begin
                if (i_ctl.enc) begin
                    n_a = r_b;
                    n_b = rotl32(r_c ^ u, t[ROT_W-1:0]) + i_k1;
                    n_c = r_d;
                    n_d = rotl32(r_a ^ t, u[ROT_W-1:0]) + i_k0;
                end else begin
                    n_a = rotr32(r_d - i_k0, u[ROT_W-1:0]) ^ t;
                    n_b = r_a;
                    n_c = rotr32(r_b - i_k1, t[ROT_W-1:0]) ^ u;
                    n_d = r_c;
                end
            end
            STEP_POST: begin
                if (i_ctl.enc) begin
                    n_a = r_a + i_k0;
                    n_c = r_c + i_k1;
                end else begin
                    n_b = r_b - i_k0;
                    n_d = r_d - i_k1;
                end
            end
            default: begin
            end
        endcase
    end

    // Load a new block or advance one step
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_a <= i_req.word_a;
            r_b <= i_req.word_b;
            r_c <= i_req.word_c;
            r_d <= i_req.word_d;
        end else if (i_ctl.en) begin
            r_a <= n_a;
            r_b <= n_b;
            r_c <= n_c;
            r_d <= n_d;
        end
    end

    assign o_resp.out_a = r_a;
    assign o_resp.out_b = r_b;
    assign o_resp.out_c = r_c;
    assign o_resp.out_d = r_d;

endmodule

`default_nettype wire

@@ hdl/rc6_block_cipher_unit.sv @@
// RC6 block cipher, 32-bit words, ROUNDS rounds, both directions.
// Configuration: write the four key registers and the key length through
// i_cfg_wr_en / i_cfg_idx / i_cfg_wdata while no request is in flight. Any
// write to a defined register marks the round keys stale.
// Request channel (i_in_valid / o_in_ready, t_req) takes one 128-bit block
// and a direction (cmd 0 decrypt, 1 encrypt). Ready is high only in idle.
// Result channel (o_out_valid / i_out_ready, t_resp) carries one block per
// request from an output register.
// Timing: one shared round unit does one whitening step or one round per
// cycle while running, ROUNDS+2 steps per request; the result is loaded
// into the output register from the done state, and the next request is
// taken only once the unit is back in idle.
// The first request after reset or a key change first expands the key: an
// init phase seeds the memories, then 3*max(2*ROUNDS+4, key words) mixing
// steps run, each in two phases (mix A, mix B), and a fetch state follows.
// Reset (synchronous, active low) clears the key registers, sets the key
// length to 16 and marks the schedule stale. A stalled receiver holds the
// result in the output register; the finished block waits in the round unit
// and no new request is taken until the output register frees up.
`default_nettype none
`include "assert_macros.svh"

module rc6_block_cipher_unit
    import rc6_pkg::*;
#(
    parameter int ROUNDS        = ROUNDS_DEF,
    parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
)(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [KEY_REG_W-1:0] i_cfg_wdata,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_req                 i_in_req,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_resp                o_out_resp
);

    localparam int PW  = $clog2(ROUNDS + 2);
    localparam int RKW = PW + 1;
    localparam logic [PW-1:0] LAST_STEP = PW'(ROUNDS + 1);

    t_state r_state;
    t_state n_state;
    logic [PW-1:0] r_step;
    logic          r_enc;
    logic          r_sched_ok;
    logic [KEY_REG_COUNT-1:0][KEY_REG_W-1:0] r_key;
    logic [KEY_LEN_W-1:0] r_key_len;
    logic          r_out_valid;
    t_resp         r_out_resp;

    logic          in_fire;
    logic          ks_start;
    logic          out_load;
    t_ks_stat      ks_stat;
    logic          ks_rk_we;
    logic [RKW-1:0]    ks_rk_wa;
    logic [WORD_W-1:0] ks_rk_wd;
    logic [RKW-1:0]    ks_rk_ra;
    logic [PW-1:0]     sel_step;
    logic              sel_enc;
    logic [PW-1:0]     pair;
    logic [RKW-1:0]    rd0_addr;
    logic [RKW-1:0]    rd1_addr;
    logic [WORD_W-1:0] rk0;
    logic [WORD_W-1:0] rk1;
    t_step_ctl         step_ctl;
    t_resp             ru_resp;
    logic              ks_entered;
    logic              out_held;

    assign in_fire = i_in_valid && o_in_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_state = r_sched_ok ? ST_RUN : ST_KEY;
                end
            end
            ST_KEY: begin
                if (ks_stat.done) begin
                    n_state = ST_FETCH;
                end
            end
            ST_FETCH: begin
                n_state = ST_RUN;
            end
            ST_RUN: begin
                if (r_step == LAST_STEP) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control outputs and key prefetch step
    always_comb begin
        o_in_ready    = 1'b0;
        ks_start      = 1'b0;
        out_load      = 1'b0;
        sel_step      = '0;
        sel_enc       = r_enc;
        step_ctl.en   = 1'b0;
        step_ctl.enc  = r_enc;
        step_ctl.kind = STEP_ROUND;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                ks_start   = i_in_valid && !r_sched_ok;
                sel_enc    = i_in_req.cmd;
            end
            ST_KEY: begin
            end
            ST_FETCH: begin
            end
            ST_RUN: begin
                step_ctl.en = 1'b1;
                sel_step    = r_step + PW'(1);
                if (r_step == '0) begin
                    step_ctl.kind = STEP_PRE;
                end else if (r_step == LAST_STEP) begin
                    step_ctl.kind = STEP_POST;
                end
            end
            ST_DONE: begin
                out_load = !r_out_valid || i_out_ready;
            end
            default: begin
            end
        endcase
    end

    // Round key pair for a step: ascending for encrypt, descending for decrypt
    always_comb begin
        pair     = sel_enc ? sel_step : LAST_STEP - sel_step;
        rd0_addr = ks_stat.busy ? ks_rk_ra : {pair, 1'b0};
        rd1_addr = {pair, 1'b1};
    end

    // Control registers and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_sched_ok  <= 1'b0;
            r_key       <= '0;
            r_key_len   <= KEY_LEN_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_RUN) begin
                r_step <= r_step + PW'(1);
            end else begin
                r_step <= '0;
            end
            if (i_cfg_wr_en) begin
                case (i_cfg_idx)
                    CFG_KEY0, CFG_KEY1, CFG_KEY2, CFG_KEY3: begin
                        r_key[i_cfg_idx[1:0]] <= i_cfg_wdata;
                        r_sched_ok            <= 1'b0;
                    end
                    CFG_KEY_LEN: begin
                        r_key_len  <= i_cfg_wdata[KEY_LEN_W-1:0];
                        r_sched_ok <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end else if (ks_stat.done) begin
                r_sched_ok <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold direction and result
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_enc <= i_in_req.cmd;
        end
        if (out_load) begin
            r_out_resp <= ru_resp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_resp  = r_out_resp;

    rc6_key_sched #(
        .ROUNDS        (ROUNDS),
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) u_key_sched (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (ks_start),
        .i_key        (r_key),
        .i_key_len    (r_key_len),
        .o_stat       (ks_stat),
        .o_rk_wr_en   (ks_rk_we),
        .o_rk_wr_addr (ks_rk_wa),
        .o_rk_wr_data (ks_rk_wd),
        .o_rk_rd_addr (ks_rk_ra),
        .i_rk_rd_data (rk0)
    );

    rc6_rk_ram #(
        .ROUNDS (ROUNDS)
    ) u_rk_ram (
        .i_clk      (i_clk),
        .i_wr_en    (ks_rk_we),
        .i_wr_addr  (ks_rk_wa),
        .i_wr_data  (ks_rk_wd),
        .i_rd0_addr (rd0_addr),
        .o_rd0_data (rk0),
        .i_rd1_addr (rd1_addr),
        .o_rd1_data (rk1)
    );

    rc6_round_unit u_round_unit (
        .i_clk  (i_clk),
        .i_load (in_fire),
        .i_req  (i_in_req),
        .i_ctl  (step_ctl),
        .i_k0   (rk0),
        .i_k1   (rk1),
        .o_resp (ru_resp)
    );

    // Conditions watched by the checks below
    assign ks_entered = (r_state == ST_KEY) && ks_stat.busy;
    assign out_held   = (r_state == ST_DONE) && r_out_valid;

    `ASSERT_SAME(a_run_no_ks, i_clk, i_rst_n, r_state == ST_RUN, !ks_stat.busy, "busy in run")
    `ASSERT_NEXT(a_stale_expands, i_clk, i_rst_n, ks_start, ks_entered, "stale key kept")
    `ASSERT_SAME(a_done_key, i_clk, i_rst_n, ks_stat.done, r_state == ST_KEY, "done outside key")
    `ASSERT_NEXT(a_out_kept, i_clk, i_rst_n, out_held && !i_out_ready, out_held, "result dropped")

endmodule

`default_nettype wire
